// ===== sv/angular_sector_artifact_overlay_assert.svh =====
// assertion helpers for the sector overlay block
`ifndef ANGULAR_SECTOR_ARTIFACT_OVERLAY_ASSERT_SVH
`define ANGULAR_SECTOR_ARTIFACT_OVERLAY_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASAO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sector overlay check failed");

// next-cycle implication
`define ASAO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sector overlay check failed");

`endif

// ===== sv/asao_pkg.sv =====
// ----------------------------------------------------------------------------
// asao_pkg
// constants, register indexes and the arctangent table of the sector overlay
// ----------------------------------------------------------------------------
package asao_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CW            = 34;   // cordic datapath width
  localparam int RSTEPS        = 17;   // remainder steps, one per angle bit
  localparam int VAL_W         = 20;
  localparam int POS_W         = 24;
  localparam int IDX_W         = 3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 20'sh80000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sh7FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_BRIGHT_WIDTH = 3'd2,
    REG_DARK_WIDTH   = 3'd3,
    REG_BRIGHT_VALUE = 3'd4,
    REG_DARK_VALUE   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] dens;
    logic signed [VAL_W-1:0] art;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
    if (s < $signed({VAL_MIN[VAL_W-1], VAL_MIN})) return VAL_MIN;
    if (s > $signed({VAL_MAX[VAL_W-1], VAL_MAX})) return VAL_MAX;
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== sv/asao_in_if.sv =====
// ----------------------------------------------------------------------------
// asao_in_if
// voxel request channel: position, density and accumulated artifact
// ----------------------------------------------------------------------------
interface asao_in_if import asao_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic signed [VAL_W-1:0] density_in;
  logic signed [VAL_W-1:0] artifact_in;

  modport source (output valid, x_pos, y_pos, density_in, artifact_in, input ready);
  modport sink   (input valid, x_pos, y_pos, density_in, artifact_in, output ready);
endinterface

// ===== sv/asao_out_if.sv =====
// ----------------------------------------------------------------------------
// asao_out_if
// result channel: chosen artifact, sector flag and the two saturated sums
// ----------------------------------------------------------------------------
interface asao_out_if import asao_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] artifact_value;
  logic                    is_dark;
  logic signed [VAL_W-1:0] density_out;
  logic signed [VAL_W-1:0] artifact_out;

  modport source (output valid, artifact_value, is_dark, density_out, artifact_out,
                  input ready);
  modport sink   (input valid, artifact_value, is_dark, density_out, artifact_out,
                  output ready);
endinterface

// ===== sv/angular_sector_artifact_overlay.sv =====
// ----------------------------------------------------------------------------
// angular_sector_artifact_overlay
// windmill artifact: polar sector of each voxel picks a bright or dark value
// ----------------------------------------------------------------------------
// Voxel requests enter on in_ch (valid/ready), results leave on out_ch in the
// same order, one result per request. Configuration is a write-only port
// (cfg_we, cfg_index, cfg_data) to be used while no request is in flight.
// The pipeline has one offset stage, one cordic setup stage, 16 cordic
// vectoring stages, one angle rounding stage, one remainder load stage,
// 17 remainder stages (one angle bit each) and one output stage with the
// saturating adders.
// Throughput is one request per cycle; the pipeline stalls as a whole only
// while the output register holds a result that out_ch does not take.
// in_ch.ready follows out_ch.ready combinationally when the output is full.
// Synchronous reset clears all valid bits and zeroes every configuration
// register, which disables the overlay (artifact 0, inputs pass through).
// ----------------------------------------------------------------------------
`include "angular_sector_artifact_overlay_assert.svh"

module angular_sector_artifact_overlay import asao_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  asao_in_if.sink          in_ch,
  asao_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0] cfg_data
);

  // configuration
  logic signed [POS_W-1:0] center_x_r, center_y_r;
  logic [15:0]             bright_width_r, dark_width_r;
  logic signed [VAL_W-1:0] bright_value_r, dark_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      bright_width_r <= '0;
      dark_width_r   <= '0;
      bright_value_r <= '0;
      dark_value_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:     center_x_r     <= cfg_data;
        REG_CENTER_Y:     center_y_r     <= cfg_data;
        REG_BRIGHT_WIDTH: bright_width_r <= cfg_data[15:0];
        REG_DARK_WIDTH:   dark_width_r   <= cfg_data[15:0];
        REG_BRIGHT_VALUE: bright_value_r <= cfg_data[VAL_W-1:0];
        REG_DARK_VALUE:   dark_value_r   <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [16:0] comb;
  assign comb = {1'b0, bright_width_r} + {1'b0, dark_width_r};

  // global stall: everything moves when the output slot is free or taken
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // offset stage
  logic                 dv_r;
  logic signed [24:0]   dx_r, dy_r;
  side_t                ds_r;

  // cordic setup and stages
  logic                 cv_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] cu_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] cvv_r [CORDIC_STAGES+1];
  logic [31:0]          cz_r [CORDIC_STAGES+1];
  logic                 czero_r [CORDIC_STAGES+1];
  logic                 cneg_r [CORDIC_STAGES+1];
  side_t                cs_r [CORDIC_STAGES+1];

  // angle stage
  logic                 av_r;
  logic [16:0]          ang_r;
  side_t                as_r;

  // remainder stages
  logic                 rv_r [RSTEPS+1];
  logic [16:0]          rr_r [RSTEPS+1];
  logic [16:0]          ra_r [RSTEPS+1];
  side_t                rs_r [RSTEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else if (en) begin
      dv_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {in_ch.x_pos[POS_W-1], in_ch.x_pos} - {center_x_r[POS_W-1], center_x_r};
      dy_r <= {in_ch.y_pos[POS_W-1], in_ch.y_pos} - {center_y_r[POS_W-1], center_y_r};
      ds_r <= '{dens: in_ch.density_in, art: in_ch.artifact_in};
    end
  end

  // setup: rotate by a half turn, fold into the right half plane
  logic signed [CW-1:0] dx_w, dy_w;
  assign dx_w = CW'(dx_r) <<< 6;
  assign dy_w = CW'(dy_r) <<< 6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STAGES; i++) cv_r[i] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= dv_r;
      for (int i = 0; i < CORDIC_STAGES; i++) cv_r[i+1] <= cv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dx_r > 0) begin
        cu_r[0]  <= dx_w;
        cvv_r[0] <= dy_w;
        cz_r[0]  <= 32'h80000000;
      end else begin
        cu_r[0]  <= -dx_w;
        cvv_r[0] <= -dy_w;
        cz_r[0]  <= '0;
      end
      czero_r[0] <= (dx_r == 0) && (dy_r == 0);
      cneg_r[0]  <= (dy_r == 0) && (dx_r < 0);
      cs_r[0]    <= ds_r;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (!cvv_r[i][CW-1]) begin
          cu_r[i+1]  <= cu_r[i] + (cvv_r[i] >>> i);
          cvv_r[i+1] <= cvv_r[i] - (cu_r[i] >>> i);
          cz_r[i+1]  <= cz_r[i] + ATAN_TURN32[i];
        end else begin
          cu_r[i+1]  <= cu_r[i] - (cvv_r[i] >>> i);
          cvv_r[i+1] <= cvv_r[i] + (cu_r[i] >>> i);
          cz_r[i+1]  <= cz_r[i] - ATAN_TURN32[i];
        end
        czero_r[i+1] <= czero_r[i];
        cneg_r[i+1]  <= cneg_r[i];
        cs_r[i+1]    <= cs_r[i];
      end
    end
  end

  // round the turn fraction to ANGLE_BITS, then express it in 1/65536 turn
  logic [31:0]           zf;
  logic [32:0]           zrnd;
  logic [ANGLE_BITS-1:0] afull;
  logic [15:0]           a16;
  assign zf    = cz_r[CORDIC_STAGES];
  assign zrnd  = {1'b0, zf} + (33'd1 << (31 - ANGLE_BITS));
  assign afull = zrnd[31 -: ANGLE_BITS];

  generate
    if (ANGLE_BITS >= 16) begin : g_trunc
      assign a16 = afull[ANGLE_BITS-1 -: 16];
    end else begin : g_widen
      assign a16 = {afull, {(16 - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (en) begin
      av_r <= cv_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (czero_r[CORDIC_STAGES])     ang_r <= 17'd32768;
      else if (cneg_r[CORDIC_STAGES]) ang_r <= 17'd65536;
      else                            ang_r <= {1'b0, a16};
      as_r <= cs_r[CORDIC_STAGES];
    end
  end

  // restoring remainder, most significant angle bit first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= RSTEPS; k++) rv_r[k] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= av_r;
      for (int k = 0; k < RSTEPS; k++) rv_r[k+1] <= rv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [17:0] t;
    if (en) begin
      rr_r[0] <= '0;
      ra_r[0] <= ang_r;
      rs_r[0] <= as_r;
      for (int k = 0; k < RSTEPS; k++) begin
        t = {rr_r[k], ra_r[k][16]};
        if (t >= {1'b0, comb}) t = t - {1'b0, comb};
        rr_r[k+1] <= t[16:0];
        ra_r[k+1] <= {ra_r[k][15:0], 1'b0};
        rs_r[k+1] <= rs_r[k];
      end
    end
  end

  // output stage
  logic                    dark_w, off_w;
  logic signed [VAL_W-1:0] val_w;
  logic signed [VAL_W-1:0] art_val_r, dens_out_r, art_out_r;
  logic                    is_dark_r;

  assign off_w  = (comb == 17'd0);
  assign dark_w = !off_w && (rr_r[RSTEPS] >= {1'b0, bright_width_r});
  assign val_w  = off_w ? '0 : (dark_w ? dark_value_r : bright_value_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= rv_r[RSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      art_val_r  <= val_w;
      is_dark_r  <= dark_w;
      dens_out_r <= sat_add(rs_r[RSTEPS].dens, val_w);
      art_out_r  <= sat_add(rs_r[RSTEPS].art, val_w);
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.artifact_value = art_val_r;
  assign out_ch.is_dark        = is_dark_r;
  assign out_ch.density_out    = dens_out_r;
  assign out_ch.artifact_out   = art_out_r;

  `ASAO_ASSERT_IMPL(a_rem_below_period, rv_r[RSTEPS] && comb != 17'd0, rr_r[RSTEPS] < comb)
  `ASAO_ASSERT_IMPL(a_dark_value, out_vld_r && is_dark_r, art_val_r == dark_value_r)
  `ASAO_ASSERT_IMPL(a_off_zero, out_vld_r && comb == 17'd0, art_val_r == '0 && !is_dark_r)
  `ASAO_ASSERT_NEXT(a_stall_hold, out_vld_r && !out_ch.ready, out_vld_r && $stable(art_out_r))

endmodule
